/* rtl/spt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package spt_pkg;

    // table geometry and protocol constants
    localparam int TABLE_BYTES  = 50;
    localparam int EEPROM_BYTES = 24;
    localparam int Q_DEPTH      = 4;
    localparam int Q_AW         = 2;

    localparam logic [7:0] BCAST_ID       = 8'hFE;
    localparam logic [7:0] SYNC_BYTE      = 8'hFF;
    localparam logic [5:0] ID_ADDR        = 6'd3;
    localparam logic [5:0] LOCK_ADDR      = 6'd47;
    localparam logic [7:0] MIN_WRITE_ADDR = 8'h03;
    localparam logic [7:0] INS_WRITE      = 8'h03;
    localparam logic [7:0] INS_REG_WRITE  = 8'h04;

    // request function codes
    localparam logic FUNC_RX   = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // packet status codes
    localparam logic [1:0] ST_NONE     = 2'd0;
    localparam logic [1:0] ST_ACCEPT   = 2'd1;
    localparam logic [1:0] ST_BAD      = 2'd2;
    localparam logic [1:0] ST_OTHER_ID = 2'd3;

    typedef enum logic [2:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_ID,
        PH_LEN,
        PH_INS,
        PH_PARAM,
        PH_SUM
    } t_rx_phase;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_COPY,
        BK_DRAIN
    } t_back_state;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_PARAM,
        CMD_READ,
        CMD_CLOSE
    } t_cmd_op;

    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
        logic [5:0] table_addr;
    } t_in_item;

    typedef struct packed {
        logic [7:0] tbl_byte;
        logic [1:0] packet_status;
    } t_out_item;

    // classified request passed from front to back
    typedef struct packed {
        t_cmd_op    op;
        logic [7:0] data;
        logic [7:0] idx;
        logic       store;
        logic       bad;
        logic [7:0] id;
        logic [7:0] ins;
        logic [7:0] length;
        logic [5:0] addr;
    } t_cmd;

    // control table contents after reset
    function automatic logic [7:0] table_init(input logic [5:0] addr);
        logic [7:0] v;
        case (addr)
            6'd0:    v = 8'd12;
            6'd2:    v = 8'd42;
            6'd3:    v = 8'd1;
            6'd4:    v = 8'd1;
            6'd5:    v = 8'hFA;
            6'd8:    v = 8'hFF;
            6'd9:    v = 8'h03;
            6'd11:   v = 8'h55;
            6'd12:   v = 8'h3C;
            6'd13:   v = 8'hBE;
            6'd14:   v = 8'hFF;
            6'd15:   v = 8'h03;
            6'd16:   v = 8'h02;
            6'd17:   v = 8'h04;
            6'd18:   v = 8'h04;
            6'd28:   v = 8'h20;
            6'd29:   v = 8'h20;
            6'd34:   v = 8'hFF;
            6'd35:   v = 8'h03;
            6'd42:   v = 8'd100;
            6'd48:   v = 8'h20;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* rtl/spt_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module spt_front #(
    parameter int PARAM_BYTES = 64
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  spt_pkg::t_in_item    i_in_item,
    input  wire                  i_q_full,
    output logic                 o_push,
    output spt_pkg::t_cmd        o_cmd
);

    localparam logic [8:0] MAX_LEN   = 9'(PARAM_BYTES + 2);
    localparam logic [8:0] BUF_BYTES = 9'(PARAM_BYTES);

    spt_pkg::t_rx_phase r_phase, n_phase;
    logic [7:0] r_id, n_id;
    logic [7:0] r_len, n_len;
    logic [7:0] r_ins, n_ins;
    logic [7:0] r_count, n_count;
    logic [7:0] r_sum, n_sum;
    logic       accept;
    logic       rx_item;
    logic [7:0] b;
    logic [7:0] count_inc;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = accept;
    assign b          = i_in_item.rx_byte;
    assign rx_item    = accept && (i_in_item.func == spt_pkg::FUNC_RX);
    assign count_inc  = r_count + 8'd1;

    // framing phase
    always_comb begin
        n_phase = r_phase;
        if (rx_item) begin
            unique case (r_phase)
                spt_pkg::PH_SYNC1: begin
                    if (b == spt_pkg::SYNC_BYTE) n_phase = spt_pkg::PH_SYNC2;
                end
                spt_pkg::PH_SYNC2: begin
                    n_phase = (b == spt_pkg::SYNC_BYTE) ? spt_pkg::PH_ID : spt_pkg::PH_SYNC1;
                end
                spt_pkg::PH_ID:  n_phase = spt_pkg::PH_LEN;
                spt_pkg::PH_LEN: n_phase = spt_pkg::PH_INS;
                spt_pkg::PH_INS: begin
                    n_phase = (r_len <= 8'd2) ? spt_pkg::PH_SUM : spt_pkg::PH_PARAM;
                end
                spt_pkg::PH_PARAM: begin
                    // remaining param count reaches zero
                    if ({1'b0, r_len} <= ({1'b0, count_inc} + 9'd2)) begin
                        n_phase = spt_pkg::PH_SUM;
                    end
                end
                spt_pkg::PH_SUM: n_phase = spt_pkg::PH_SYNC1;
                default:         n_phase = spt_pkg::PH_SYNC1;
            endcase
        end
    end

    // request classification and header fields
    always_comb begin
        n_id    = r_id;
        n_len   = r_len;
        n_ins   = r_ins;
        n_count = r_count;
        n_sum   = r_sum;
        o_cmd        = '0;
        o_cmd.op     = spt_pkg::CMD_NONE;
        o_cmd.data   = b;
        o_cmd.idx    = r_count;
        o_cmd.id     = r_id;
        o_cmd.ins    = r_ins;
        o_cmd.length = r_len;
        o_cmd.addr   = i_in_item.table_addr;
        if (i_in_item.func == spt_pkg::FUNC_READ) begin
            o_cmd.op = spt_pkg::CMD_READ;
        end else begin
            unique case (r_phase)
                spt_pkg::PH_SYNC2: begin
                    if (b == spt_pkg::SYNC_BYTE) n_sum = 8'd0;
                end
                spt_pkg::PH_ID: begin
                    n_id  = b;
                    n_sum = r_sum + b;
                end
                spt_pkg::PH_LEN: begin
                    n_len = b;
                    n_sum = r_sum + b;
                end
                spt_pkg::PH_INS: begin
                    n_ins   = b;
                    n_sum   = r_sum + b;
                    n_count = 8'd0;
                end
                spt_pkg::PH_PARAM: begin
                    o_cmd.op    = spt_pkg::CMD_PARAM;
                    o_cmd.store = ({1'b0, r_count} < BUF_BYTES);
                    n_count     = count_inc;
                    n_sum       = r_sum + b;
                end
                spt_pkg::PH_SUM: begin
                    o_cmd.op  = spt_pkg::CMD_CLOSE;
                    o_cmd.bad = (b != ~r_sum) || ({1'b0, r_len} > MAX_LEN);
                end
                default: begin
                end
            endcase
        end
    end

    // header registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= spt_pkg::PH_SYNC1;
            r_id    <= '0;
            r_len   <= '0;
            r_ins   <= '0;
            r_count <= '0;
            r_sum   <= '0;
        end else if (rx_item) begin
            r_phase <= n_phase;
            r_id    <= n_id;
            r_len   <= n_len;
            r_ins   <= n_ins;
            r_count <= n_count;
            r_sum   <= n_sum;
        end
    end

endmodule

`default_nettype wire

/* rtl/spt_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module spt_queue (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_push,
    input  spt_pkg::t_cmd  i_cmd,
    output logic           o_full,
    input  wire            i_pop,
    output logic           o_valid,
    output spt_pkg::t_cmd  o_cmd
);

    localparam logic [spt_pkg::Q_AW:0] Q_FULL = (spt_pkg::Q_AW + 1)'(spt_pkg::Q_DEPTH);
    localparam logic [spt_pkg::Q_AW-1:0] PTR_ONE = (spt_pkg::Q_AW)'(1);
    localparam logic [spt_pkg::Q_AW:0]   CNT_ONE = (spt_pkg::Q_AW + 1)'(1);

    spt_pkg::t_cmd             r_mem [spt_pkg::Q_DEPTH];
    logic [spt_pkg::Q_AW-1:0]  r_wp;
    logic [spt_pkg::Q_AW-1:0]  r_rp;
    logic [spt_pkg::Q_AW:0]    r_cnt;
    logic                      do_push;
    logic                      do_pop;

    assign o_full  = (r_cnt == Q_FULL);
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_cmd;
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + PTR_ONE;
            if (do_pop)  r_rp <= r_rp + PTR_ONE;
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + CNT_ONE;
                2'b01:   r_cnt <= r_cnt - CNT_ONE;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/spt_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module spt_back #(
    parameter int PARAM_BYTES = 64
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_q_valid,
    input  spt_pkg::t_cmd       i_cmd,
    output logic                o_pop,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output spt_pkg::t_out_item  o_out_item
);

    localparam int PW = $clog2(PARAM_BYTES);
    localparam logic [5:0] TB_LAST = 6'(spt_pkg::TABLE_BYTES);
    localparam logic [5:0] EE_END  = 6'(spt_pkg::EEPROM_BYTES);
    localparam logic [8:0] TB_END9 = 9'(spt_pkg::TABLE_BYTES);

    spt_pkg::t_back_state r_state, n_state;

    // parameter buffer and control table
    logic [7:0] r_pmem [PARAM_BYTES];
    logic [7:0] r_tmem [spt_pkg::TABLE_BYTES];
    logic [spt_pkg::TABLE_BYTES-1:0] r_tvalid;

    logic [7:0]    r_start;
    logic [7:0]    r_id_byte;
    logic [7:0]    r_lock_byte;
    logic [5:0]    r_addr;
    logic [PW-1:0] r_rd_idx;
    logic [7:0]    r_left;
    logic          r_wr_valid;
    logic          r_wr_skip;
    logic [5:0]    r_wr_addr;
    logic [7:0]    r_pq;
    logic [7:0]    r_tq;
    logic          r_tq_valid;
    logic          r_rd_inrange;
    logic [7:0]    r_rd_init;
    logic          r_out_valid;
    spt_pkg::t_out_item r_out;

    logic       out_free;
    logic       do_copy;
    logic [7:0] wr_count;
    logic [1:0] close_status;
    logic       rd_inrange;
    logic       tbl_we;
    logic       load_out;
    spt_pkg::t_out_item out_val;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign wr_count    = i_cmd.length - 8'd3;
    assign rd_inrange  = (i_cmd.addr < TB_LAST);
    assign tbl_we      = r_wr_valid && !r_wr_skip;

    // checksum verdict, id match and write range check
    always_comb begin
        if (i_cmd.bad) begin
            close_status = spt_pkg::ST_BAD;
        end else if (i_cmd.id != spt_pkg::BCAST_ID && i_cmd.id != r_id_byte) begin
            close_status = spt_pkg::ST_OTHER_ID;
        end else begin
            close_status = spt_pkg::ST_ACCEPT;
        end
        do_copy = (close_status == spt_pkg::ST_ACCEPT)
               && (i_cmd.ins == spt_pkg::INS_WRITE || i_cmd.ins == spt_pkg::INS_REG_WRITE)
               && (i_cmd.length > 8'd3)
               && (r_start >= spt_pkg::MIN_WRITE_ADDR)
               && (({1'b0, r_start} + {1'b0, wr_count}) <= TB_END9);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            spt_pkg::BK_IDLE: begin
                if (i_q_valid && out_free) begin
                    if (i_cmd.op == spt_pkg::CMD_READ) begin
                        n_state = spt_pkg::BK_READ;
                    end else if (i_cmd.op == spt_pkg::CMD_CLOSE && do_copy) begin
                        n_state = spt_pkg::BK_COPY;
                    end
                end
            end
            spt_pkg::BK_READ: n_state = spt_pkg::BK_IDLE;
            spt_pkg::BK_COPY: begin
                if (r_left == 8'd1) n_state = spt_pkg::BK_DRAIN;
            end
            spt_pkg::BK_DRAIN: n_state = spt_pkg::BK_IDLE;
            default:           n_state = spt_pkg::BK_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_pop    = 1'b0;
        load_out = 1'b0;
        out_val  = '0;
        unique case (r_state)
            spt_pkg::BK_IDLE: begin
                o_pop = i_q_valid && out_free;
                if (o_pop && i_cmd.op != spt_pkg::CMD_READ) begin
                    load_out = 1'b1;
                    if (i_cmd.op == spt_pkg::CMD_CLOSE) out_val.packet_status = close_status;
                    else                                out_val.packet_status = spt_pkg::ST_NONE;
                end
            end
            spt_pkg::BK_READ: begin
                load_out = 1'b1;
                if (r_rd_inrange) out_val.tbl_byte = r_tq_valid ? r_tq : r_rd_init;
                out_val.packet_status = spt_pkg::ST_NONE;
            end
            default: begin
            end
        endcase
    end

    // state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= spt_pkg::BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out)         r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) r_out <= out_val;
    end

    // parameter buffer write and copy read
    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.op == spt_pkg::CMD_PARAM && i_cmd.store) begin
            r_pmem[i_cmd.idx[PW-1:0]] <= i_cmd.data;
        end
        r_pq <= r_pmem[r_rd_idx];
    end

    // start address kept beside the buffer
    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.op == spt_pkg::CMD_PARAM && i_cmd.store && i_cmd.idx == 8'd0) begin
            r_start <= i_cmd.data;
        end
    end

    // copy sequencer counters
    always_ff @(posedge i_clk) begin
        if (r_state == spt_pkg::BK_IDLE) begin
            r_addr   <= r_start[5:0];
            r_rd_idx <= PW'(1);
            r_left   <= wr_count;
        end else if (r_state == spt_pkg::BK_COPY) begin
            r_addr   <= r_addr + 6'd1;
            r_rd_idx <= r_rd_idx + PW'(1);
            r_left   <= r_left - 8'd1;
        end
    end

    // table write stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_valid <= 1'b0;
        end else begin
            r_wr_valid <= (r_state == spt_pkg::BK_COPY);
        end
        r_wr_addr <= r_addr;
        r_wr_skip <= (r_addr < EE_END) && (r_lock_byte != 8'd0);
    end

    // control table memory
    always_ff @(posedge i_clk) begin
        if (tbl_we) r_tmem[r_wr_addr] <= r_pq;
        if (o_pop && i_cmd.op == spt_pkg::CMD_READ && rd_inrange) begin
            r_tq       <= r_tmem[i_cmd.addr];
            r_tq_valid <= r_tvalid[i_cmd.addr];
        end
        r_rd_inrange <= rd_inrange;
        r_rd_init    <= spt_pkg::table_init(i_cmd.addr);
    end

    // written flags and shadow copies of id and lock bytes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid    <= '0;
            r_id_byte   <= spt_pkg::table_init(spt_pkg::ID_ADDR);
            r_lock_byte <= spt_pkg::table_init(spt_pkg::LOCK_ADDR);
        end else if (tbl_we) begin
            r_tvalid[r_wr_addr] <= 1'b1;
            if (r_wr_addr == spt_pkg::ID_ADDR)   r_id_byte   <= r_pq;
            if (r_wr_addr == spt_pkg::LOCK_ADDR) r_lock_byte <= r_pq;
        end
    end

endmodule

`default_nettype wire

/* rtl/servo_packet_parser_table_writer.sv */
// A result passes the request queue and the result register, a table read also the table read
// register. Throughput: one request per cycle while the queue has room; a table read holds the
// back end in BK_READ, and a checksum byte that closes an accepted write keeps the table writer
// busy in BK_COPY and BK_DRAIN (one table byte per cycle from the parameter buffer), while the
// front keeps taking requests until its 4-entry queue fills.
// Reset: synchronous, active low; the control table reads its default contents at once.
`timescale 1ns / 1ps
`default_nettype none

module servo_packet_parser_table_writer #(
    parameter int PARAM_BYTES = 64
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  spt_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output spt_pkg::t_out_item  o_out_item
);

    logic          q_full;
    logic          push;
    logic          pop;
    logic          q_valid;
    spt_pkg::t_cmd front_cmd;
    spt_pkg::t_cmd back_cmd;

    // byte framing and classification
    spt_front #(
        .PARAM_BYTES (PARAM_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_cmd      (front_cmd)
    );

    // request queue between the two halves
    spt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (back_cmd)
    );

    // table access and packet execution
    spt_back #(
        .PARAM_BYTES (PARAM_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_cmd       (back_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

/* bench/servo_response_checker.sv */
`timescale 1ns / 1ps

module servo_response_checker (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  wire                 i_in_ready,
    input  spt_pkg::t_in_item   i_in_item,
    input  wire                 i_out_valid,
    input  wire                 i_out_ready,
    input  spt_pkg::t_out_item  i_out_item,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_accept_count,
    output int                  o_bad_count,
    output int                  o_other_id_count,
    output int                  o_read_count
);

    localparam int PARAM_DEPTH = 64;

    // mirror of the parser state
    spt_pkg::t_rx_phase parse_phase;
    logic [7:0] pkt_id;
    logic [7:0] pkt_len;
    logic [7:0] pkt_ins;
    logic [7:0] param_cnt;
    logic [7:0] run_sum;
    logic [7:0] params [PARAM_DEPTH];
    logic [7:0] ctrl_table [spt_pkg::TABLE_BYTES];

    spt_pkg::t_out_item awaited_responses [$];

    // factory contents of the control table, 16-bit entries little endian
    task automatic load_factory_table();
        for (int a = 0; a < spt_pkg::TABLE_BYTES; a++) ctrl_table[a] = 8'h00;
        ctrl_table[0]  = 8'd12;
        ctrl_table[2]  = 8'd42;
        ctrl_table[3]  = 8'd1;
        ctrl_table[4]  = 8'd1;
        ctrl_table[5]  = 8'hFA;
        ctrl_table[8]  = 8'hFF;
        ctrl_table[9]  = 8'h03;
        ctrl_table[11] = 8'h55;
        ctrl_table[12] = 8'h3C;
        ctrl_table[13] = 8'hBE;
        ctrl_table[14] = 8'hFF;
        ctrl_table[15] = 8'h03;
        ctrl_table[16] = 8'h02;
        ctrl_table[17] = 8'h04;
        ctrl_table[18] = 8'h04;
        ctrl_table[28] = 8'h20;
        ctrl_table[29] = 8'h20;
        ctrl_table[34] = 8'hFF;
        ctrl_table[35] = 8'h03;
        ctrl_table[42] = 8'd100;
        ctrl_table[48] = 8'h20;
    endtask

    // copy the write payload into the table, honouring range and lock rules
    task automatic store_write();
        int count;
        int start;
        int a;
        count = int'(pkt_len) - 3;
        start = int'(params[0]);
        if (count > 0 && start >= int'(spt_pkg::MIN_WRITE_ADDR) &&
            start + count <= spt_pkg::TABLE_BYTES) begin
            for (int i = 0; i < count; i++) begin
                a = start + i;
                if (!(a < spt_pkg::EEPROM_BYTES && ctrl_table[spt_pkg::LOCK_ADDR] != 8'h00))
                    ctrl_table[a] = params[(i + 1) % PARAM_DEPTH];
            end
        end
    endtask

    // advance the parser by one request and work out its response
    task automatic parse_and_respond(input spt_pkg::t_in_item req,
                                     output spt_pkg::t_out_item res);
        logic [7:0] b;
        b = req.rx_byte;
        res = '0;
        if (req.func == spt_pkg::FUNC_READ) begin
            if (req.table_addr < spt_pkg::TABLE_BYTES)
                res.tbl_byte = ctrl_table[req.table_addr];
        end else begin
            case (parse_phase)
                spt_pkg::PH_SYNC1: begin
                    if (b == spt_pkg::SYNC_BYTE) parse_phase = spt_pkg::PH_SYNC2;
                end
                spt_pkg::PH_SYNC2: begin
                    if (b == spt_pkg::SYNC_BYTE) begin
                        parse_phase = spt_pkg::PH_ID;
                        run_sum = 8'h00;
                    end else begin
                        parse_phase = spt_pkg::PH_SYNC1;
                    end
                end
                spt_pkg::PH_ID: begin
                    pkt_id = b;
                    run_sum = run_sum + b;
                    parse_phase = spt_pkg::PH_LEN;
                end
                spt_pkg::PH_LEN: begin
                    pkt_len = b;
                    run_sum = run_sum + b;
                    parse_phase = spt_pkg::PH_INS;
                end
                spt_pkg::PH_INS: begin
                    pkt_ins = b;
                    run_sum = run_sum + b;
                    param_cnt = 8'h00;
                    parse_phase = (pkt_len <= 8'd2) ? spt_pkg::PH_SUM : spt_pkg::PH_PARAM;
                end
                spt_pkg::PH_PARAM: begin
                    if (param_cnt < PARAM_DEPTH) params[param_cnt[5:0]] = b;
                    param_cnt = param_cnt + 8'd1;
                    run_sum = run_sum + b;
                    if (int'(pkt_len) - int'(param_cnt) <= 2) parse_phase = spt_pkg::PH_SUM;
                end
                spt_pkg::PH_SUM: begin
                    if (b != 8'(~run_sum) || int'(pkt_len) > PARAM_DEPTH + 2) begin
                        res.packet_status = spt_pkg::ST_BAD;
                    end else if (pkt_id != spt_pkg::BCAST_ID &&
                                 pkt_id != ctrl_table[spt_pkg::ID_ADDR]) begin
                        res.packet_status = spt_pkg::ST_OTHER_ID;
                    end else begin
                        if (pkt_ins == spt_pkg::INS_WRITE || pkt_ins == spt_pkg::INS_REG_WRITE)
                            store_write();
                        res.packet_status = spt_pkg::ST_ACCEPT;
                    end
                    parse_phase = spt_pkg::PH_SYNC1;
                end
                default: begin
                    parse_phase = spt_pkg::PH_SYNC1;
                end
            endcase
        end
    endtask

    // watch both channels: check responses first, then queue new predictions
    always @(posedge i_clk) begin
        spt_pkg::t_out_item fresh;
        spt_pkg::t_out_item oldest;
        if (!i_rst_n) begin
            parse_phase = spt_pkg::PH_SYNC1;
            pkt_id = 8'h00;
            pkt_len = 8'h00;
            pkt_ins = 8'h00;
            param_cnt = 8'h00;
            run_sum = 8'h00;
            for (int k = 0; k < PARAM_DEPTH; k++) params[k] = 8'h00;
            load_factory_table();
            awaited_responses.delete();
            o_fail_count = 0;
            o_accept_count = 0;
            o_bad_count = 0;
            o_other_id_count = 0;
            o_read_count = 0;
            o_pending <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (awaited_responses.size() == 0) begin
                    $error("response with nothing awaited: tbl_byte %0h, packet_status %0d",
                           i_out_item.tbl_byte, i_out_item.packet_status);
                    o_fail_count++;
                end else begin
                    oldest = awaited_responses.pop_front();
                    if (i_out_item.tbl_byte !== oldest.tbl_byte) begin
                        $error("tbl_byte: expected %0h, actual %0h",
                               oldest.tbl_byte, i_out_item.tbl_byte);
                        o_fail_count++;
                    end
                    if (i_out_item.packet_status !== oldest.packet_status) begin
                        $error("packet_status: expected %0d, actual %0d",
                               oldest.packet_status, i_out_item.packet_status);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                parse_and_respond(i_in_item, fresh);
                awaited_responses.push_back(fresh);
                if (i_in_item.func == spt_pkg::FUNC_READ) o_read_count++;
                case (fresh.packet_status)
                    spt_pkg::ST_ACCEPT:   o_accept_count++;
                    spt_pkg::ST_BAD:      o_bad_count++;
                    spt_pkg::ST_OTHER_ID: o_other_id_count++;
                    default: ;
                endcase
            end
            o_pending <= awaited_responses.size();
        end
    end

endmodule

/* bench/servo_packet_parser_table_writer_tb.sv */
`timescale 1ns / 1ps

module servo_packet_parser_table_writer_tb;

    localparam int TOTAL_ITEMS = 1375;
    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_AT     = 200;
    localparam int HOLD_CYCLES = 300;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    spt_pkg::t_in_item  in_item = '0;
    logic               out_ready = 1'b0;
    wire                in_ready;
    wire                out_valid;
    spt_pkg::t_out_item out_item;

    int fail_count;
    int pending;
    int accept_count;
    int bad_count;
    int other_id_count;
    int read_count;

    int         sent_count = 0;
    bit         steady = 1'b0;
    logic [7:0] guess_id = 8'd1;
    logic [7:0] pkt_body [256];

    servo_packet_parser_table_writer DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    servo_response_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_in_item        (in_item),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_out_item       (out_item),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_accept_count   (accept_count),
        .o_bad_count      (bad_count),
        .o_other_id_count (other_id_count),
        .o_read_count     (read_count)
    );

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    initial begin : watchdog
        int cyc;
        for (cyc = 0; cyc < CYCLE_LIMIT; cyc++) @(posedge clk);
        $display("end of test: mismatches");
        $finish;
    end

    // present one request after a random gap (none while steady) and hold it until taken
    task automatic offer(input spt_pkg::t_in_item req);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= req;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent_count++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        spt_pkg::t_in_item req;
        req.func = spt_pkg::FUNC_RX;
        req.rx_byte = b;
        req.table_addr = 6'($urandom);
        offer(req);
    endtask

    task automatic send_read(input logic [5:0] addr);
        spt_pkg::t_in_item req;
        req.func = spt_pkg::FUNC_READ;
        req.rx_byte = 8'($urandom);
        req.table_addr = addr;
        offer(req);
    endtask

    function automatic logic [7:0] data_byte();
        return ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
    endfunction

    // frame pkt_body as a packet, with table reads slipped in between bytes
    task automatic send_packet(input logic [7:0] id, input logic [7:0] len,
                               input logic [7:0] ins, input bit spoil);
        int         nparams;
        logic [7:0] sum;
        nparams = (len >= 8'd3) ? int'(len) - 2 : 0;
        sum = id + len + ins;
        for (int k = 0; k < nparams; k++) sum = sum + pkt_body[k];
        sum = ~sum;
        if (spoil) sum = sum ^ 8'($urandom_range(1, 255));
        send_byte(spt_pkg::SYNC_BYTE);
        send_byte(spt_pkg::SYNC_BYTE);
        send_byte(id);
        send_byte(len);
        send_byte(ins);
        for (int k = 0; k < nparams; k++) begin
            if ($urandom_range(0, 9) == 0) send_read(6'($urandom));
            send_byte(pkt_body[k]);
        end
        if ($urandom_range(0, 9) == 0) send_read(6'($urandom));
        send_byte(sum);
    endtask

    // one random packet, mostly well formed writes
    task automatic random_packet();
        int         pick;
        int         count;
        int         start;
        int         lo;
        int         len;
        logic [7:0] id;
        logic [7:0] ins;
        bit         spoil;
        pick = $urandom_range(0, 99);
        if (pick < 60) id = spt_pkg::BCAST_ID;
        else if (pick < 85) id = guess_id;
        else id = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 40) ins = spt_pkg::INS_WRITE;
        else if (pick < 75) ins = spt_pkg::INS_REG_WRITE;
        else ins = 8'($urandom);
        spoil = ($urandom_range(0, 9) == 0);
        count = 0;
        start = 0;
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
            // oversized, refused as too long
            len = ($urandom_range(0, 4) == 0) ? 255 : $urandom_range(67, 72);
            for (int k = 0; k < len - 2; k++) pkt_body[k] = 8'($urandom);
        end else if (pick < 8) begin
            // short length, no payload to store
            len = $urandom_range(0, 3);
            pkt_body[0] = 8'($urandom);
        end else begin
            count = (pick < 70) ? $urandom_range(1, 8) : $urandom_range(1, 47);
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                start = $urandom_range(3, spt_pkg::TABLE_BYTES - count);
            end else if (pick < 90) begin
                start = $urandom_range(0, 2);
            end else begin
                // run past the end of the table
                count = $urandom_range(1, 63);
                lo = spt_pkg::TABLE_BYTES - count + 1;
                if (lo < 0) lo = 0;
                start = $urandom_range(lo, 255);
            end
            len = count + 3;
            pkt_body[0] = 8'(start);
            for (int k = 1; k <= count; k++) pkt_body[k] = data_byte();
        end
        if (!spoil && (ins == spt_pkg::INS_WRITE || ins == spt_pkg::INS_REG_WRITE) &&
            start == 3 && count > 0 && (id == spt_pkg::BCAST_ID || id == guess_id))
            guess_id = pkt_body[1];
        send_packet(id, 8'(len), ins, spoil);
    endtask

    // broken framing and stray requests
    task automatic line_noise();
        int pick;
        pick = $urandom_range(0, 3);
        case (pick)
            0: begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
            end
            1: begin
                send_byte(spt_pkg::SYNC_BYTE);
                send_byte(8'($urandom_range(0, 254)));
            end
            2: begin
                // header cut short, the next bytes land as its body
                send_byte(spt_pkg::SYNC_BYTE);
                send_byte(spt_pkg::SYNC_BYTE);
                send_byte(spt_pkg::BCAST_ID);
                send_byte(8'($urandom_range(3, 10)));
            end
            default: begin
                repeat ($urandom_range(1, 6)) send_read(6'($urandom));
            end
        endcase
    endtask

    // response side: random stalls, calm stretches and one long hold-off
    initial begin : response_sink
        int stall;
        int taken;
        bit calm;
        taken = 0;
        calm = 1'b0;
        while (!rst_n) @(posedge clk);
        forever begin
            if (taken % 64 == 0) calm = ($urandom_range(0, 3) == 0);
            if (taken == HOLD_AT) stall = HOLD_CYCLES;
            else if (calm) stall = 0;
            else stall = $urandom_range(0, 6);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            taken++;
        end
    end

    // stimulus and verdict
    initial begin : stimulus
        int pick;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // table reads at both ends and out of range
        send_read(6'd0);
        send_read(6'd49);
        send_read(6'd50);
        send_read(6'd63);
        // second sync mismatch
        send_byte(spt_pkg::SYNC_BYTE);
        send_byte(8'h00);
        // short length ping to the table id
        send_packet(8'd1, 8'd2, 8'h01, 1'b0);
        // write below the lowest writable address
        pkt_body[0] = 8'd2;
        pkt_body[1] = 8'hAA;
        send_packet(spt_pkg::BCAST_ID, 8'd4, spt_pkg::INS_WRITE, 1'b0);
        // write running past the end
        pkt_body[0] = 8'd49;
        pkt_body[1] = 8'hFF;
        pkt_body[2] = 8'h55;
        send_packet(spt_pkg::BCAST_ID, 8'd5, spt_pkg::INS_REG_WRITE, 1'b0);

        while (sent_count < TOTAL_ITEMS) begin
            steady = ($urandom_range(0, 7) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                line_noise();
            end else if (pick < 16) begin
                // set or clear the lock byte
                pkt_body[0] = 8'(spt_pkg::LOCK_ADDR);
                pkt_body[1] = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom);
                send_packet(spt_pkg::BCAST_ID, 8'd4, spt_pkg::INS_WRITE, 1'b0);
            end else if (pick < 20) begin
                for (int a = 0; a < spt_pkg::TABLE_BYTES; a += $urandom_range(1, 8))
                    send_read(6'(a));
            end else begin
                random_packet();
            end
        end
        in_valid <= 1'b0;

        // drain
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);

        $display("covered %0d requests: %0d packets accepted, %0d bad, %0d with other id",
                 sent_count, accept_count, bad_count, other_id_count);
        $display("%0d table reads checked, lock toggling and a long response hold-off",
                 read_count);
        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
